>>> hdl/scvs_pkg.sv
// Shared types, codes and helper functions for the sprite command vertex setup unit.
package scvs_pkg;

    localparam int CfgIndexWidth = 1;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_LOCAL_X = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_LOCAL_Y = 1'd1;

    // command kinds
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_SCALED    = 3'd1;
    localparam logic [2:0] MODE_DISTORTED = 3'd2;
    localparam logic [2:0] MODE_POLYGON   = 3'd3;
    localparam logic [2:0] MODE_POLYLINE  = 3'd4;
    localparam logic [2:0] MODE_LINE      = 3'd5;

    // status codes
    localparam logic [1:0] STATUS_DRAW     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;
    localparam logic [1:0] STATUS_BAD_CMOD = 2'd3;

    localparam logic [2:0] MaxColorMode = 3'd5;

    localparam logic [15:0] COORD_EXT_TEST = 16'h7000;
    localparam logic [15:0] COORD_EXT_SET  = 16'hF000;
    localparam logic [15:0] COORD_CLR_MASK = 16'hF800;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] size_word;
        logic [15:0] control_word;
        logic [15:0] draw_mode_word;
        logic [3:0][15:0] raw_x;   // index 0..3 = A..D
        logic [3:0][15:0] raw_y;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [3:0][15:0] vert_x;
        logic [3:0][15:0] vert_y;
        logic [8:0]       sprite_width;
        logic [7:0]       sprite_height;
        logic [1:0]       flip_bits;
    } result_t;

    // coordinate widening: any of bits 14:12 set fills bits 15:12, else only bits 10:0 are kept
    function automatic logic [15:0] conv_coord(input logic [15:0] a);
        logic [15:0] r;
        if ((a & COORD_EXT_TEST) != 16'h0000)
            r = a | COORD_EXT_SET;
        else
            r = a & ~COORD_CLR_MASK;
        return r;
    endfunction

    // signed halving, truncated toward zero
    function automatic logic [15:0] half16(input logic [15:0] v);
        logic signed [15:0] t;
        t = $signed(v + {15'd0, v[15]});
        return 16'($signed(t >>> 1));
    endfunction

endpackage

>>> hdl/scvs_vertex_calc.sv
// Combinational vertex, size, flip and status computation for one command.
module scvs_vertex_calc
(
    input  scvs_pkg::cmd_t    cmd,
    input  logic [15:0]       local_x,
    input  logic [15:0]       local_y,
    output scvs_pkg::result_t res
);

    logic [3:0][15:0] cx;
    logic [3:0][15:0] cy;
    logic [8:0]  w;
    logic [7:0]  h;
    logic [1:0]  flip;
    logic        bad_size;
    logic        bad_cmod;
    logic        empty;

    // normal sprite
    logic [15:0] n_ax, n_ay, n_dw, n_dh, n_bx, n_dy;

    // scaled sprite
    logic [3:0]  zp;
    logic        anchored;
    logic [15:0] s_rw, s_rh, s_x, s_y;
    logic [15:0] s_x0, s_x1, s_y0, s_y2;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cx[i] = scvs_pkg::conv_coord(cmd.raw_x[i]);
            cy[i] = scvs_pkg::conv_coord(cmd.raw_y[i]);
        end
    end

    assign w        = {cmd.size_word[13:8], 3'b000};
    assign h        = cmd.size_word[7:0];
    assign flip     = cmd.control_word[5:4];
    assign bad_size = cmd.size_word[15];
    assign bad_cmod = cmd.draw_mode_word[5:3] > scvs_pkg::MaxColorMode;
    assign empty    = (w == 9'd0) || (h == 8'd0);

    assign n_ax = cx[0] + local_x;
    assign n_ay = cy[0] + local_y;
    assign n_dw = (w == 9'd0) ? 16'd1 : {7'd0, w};
    assign n_dh = (h == 8'd0) ? 16'd1 : {8'd0, h};
    assign n_bx = n_ax + n_dw;
    assign n_dy = n_ay + n_dh;

    assign zp = cmd.control_word[11:8];

    always_comb
    begin
        anchored = zp inside {4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15};
        s_rw = 16'd0;
        s_rh = 16'd0;
        s_x  = cx[0];
        s_y  = cy[0];
        if (zp == 4'd0)
        begin
            s_rw = cx[2] - cx[0];
            s_rh = cy[2] - cy[0];
        end
        else if (anchored)
        begin
            s_rw = cx[1];
            s_rh = cy[1];
            case (zp[1:0])
                2'd2:    s_x = cx[0] - scvs_pkg::half16(cx[1]);
                2'd3:    s_x = cx[0] - cx[1];
                default: s_x = cx[0];
            endcase
            case (zp[3:2])
                2'd2:    s_y = cy[0] - scvs_pkg::half16(cy[1]);
                2'd3:    s_y = cy[0] - cy[1];
                default: s_y = cy[0];
            endcase
        end
    end

    assign s_x0 = s_x + local_x;
    assign s_x1 = s_x + s_rw + local_x;
    assign s_y0 = s_y + local_y;
    assign s_y2 = s_y + s_rh + local_y;

    always_comb
    begin
        res.status        = scvs_pkg::STATUS_DRAW;
        res.vert_x        = '0;
        res.vert_y        = '0;
        res.sprite_width  = 9'd1;
        res.sprite_height = 8'd1;
        res.flip_bits     = 2'd0;

        if (cmd.mode <= scvs_pkg::MODE_DISTORTED)
        begin
            res.sprite_width  = w;
            res.sprite_height = h;
            res.flip_bits     = flip;
            if (empty)
                res.status = scvs_pkg::STATUS_EMPTY;
        end

        case (cmd.mode)
            scvs_pkg::MODE_NORMAL:
            begin
                if (bad_size || bad_cmod)
                begin
                    res.status        = bad_size ? scvs_pkg::STATUS_BAD_SIZE
                                                 : scvs_pkg::STATUS_BAD_CMOD;
                    res.sprite_width  = 9'd0;
                    res.sprite_height = 8'd0;
                    res.flip_bits     = 2'd0;
                end
                else
                begin
                    res.vert_x = {n_ax, n_bx, n_bx, n_ax};
                    res.vert_y = {n_dy, n_dy, n_ay, n_ay};
                end
            end
            scvs_pkg::MODE_SCALED:
            begin
                res.vert_x = {s_x0, s_x1, s_x1, s_x0};
                res.vert_y = {s_y2, s_y2, s_y0, s_y0};
                if (zp == 4'd0)
                begin
                    // inclusive far edge; degenerate spans shift as a whole
                    if ($signed(s_x1) > $signed(s_x0))
                        res.vert_x = {s_x0, s_x1 + 16'd1, s_x1 + 16'd1, s_x0};
                    else
                        res.vert_x = {s_x0 + 16'd1, s_x1 + 16'd1, s_x1 + 16'd1, s_x0 + 16'd1};
                    if ($signed(s_y2) > $signed(s_y0))
                        res.vert_y = {s_y2 + 16'd1, s_y2 + 16'd1, s_y0, s_y0};
                    else
                        res.vert_y = {s_y2 + 16'd1, s_y2 + 16'd1, s_y0 + 16'd1, s_y0 + 16'd1};
                end
                else if (anchored)
                begin
                    res.vert_x = {s_x0, s_x1 + 16'd1, s_x1 + 16'd1, s_x0};
                    res.vert_y = {s_y2 + 16'd1, s_y2 + 16'd1, s_y0, s_y0};
                end
            end
            scvs_pkg::MODE_DISTORTED, scvs_pkg::MODE_POLYGON, scvs_pkg::MODE_POLYLINE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res.vert_x[i] = cx[i] + local_x;
                    res.vert_y[i] = cy[i] + local_y;
                end
            end
            scvs_pkg::MODE_LINE:
            begin
                res.vert_x[0] = cx[0] + local_x;
                res.vert_y[0] = cy[0] + local_y;
                res.vert_x[1] = cx[1] + local_x;
                res.vert_y[1] = cy[1] + local_y;
                res.vert_x[2] = res.vert_x[1];
                res.vert_y[2] = res.vert_y[1];
                res.vert_x[3] = res.vert_x[0];
                res.vert_y[3] = res.vert_y[0];
            end
            default:
            begin
                res.sprite_width  = 9'd0;
                res.sprite_height = 8'd0;
                res.flip_bits     = 2'd0;
            end
        endcase
    end

endmodule

>>> hdl/sprite_command_vertex_setup_unit.sv
// Sprite command vertex setup: two-stage command register and result register.
// Latency: a command taken at a clock edge shows its result, with done high,
//   for one cycle starting at the next edge.
// Throughput: one command per cycle; busy stays low, the result register sets the pace.
// Results cannot be held off by the receiver; done marks each for one cycle only.
// Reset clears the local origin registers and the stage valid flags.
module sprite_command_vertex_setup_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            mode,
    input  logic [15:0]                           size_word,
    input  logic [15:0]                           control_word,
    input  logic [15:0]                           draw_mode_word,
    input  logic [15:0]                           raw_ax,
    input  logic [15:0]                           raw_ay,
    input  logic [15:0]                           raw_bx,
    input  logic [15:0]                           raw_by,
    input  logic [15:0]                           raw_cx,
    input  logic [15:0]                           raw_cy,
    input  logic [15:0]                           raw_dx,
    input  logic [15:0]                           raw_dy,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scvs_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [15:0]                           cfg_data,

    output logic                                  done,
    output logic [1:0]                            status,
    output logic signed [15:0]                    vert_ax,
    output logic signed [15:0]                    vert_ay,
    output logic signed [15:0]                    vert_bx,
    output logic signed [15:0]                    vert_by,
    output logic signed [15:0]                    vert_cx,
    output logic signed [15:0]                    vert_cy,
    output logic signed [15:0]                    vert_dx,
    output logic signed [15:0]                    vert_dy,
    output logic [8:0]                            sprite_width,
    output logic [7:0]                            sprite_height,
    output logic [1:0]                            flip_bits
);

    logic [15:0]       local_x_reg;
    logic [15:0]       local_y_reg;
    logic              cmd_valid_reg;
    scvs_pkg::cmd_t    cmd_reg;
    scvs_pkg::cmd_t    cmd_next;
    logic              res_valid_reg;
    scvs_pkg::result_t res_reg;
    scvs_pkg::result_t res_next;
    logic              accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        cmd_next.mode           = mode;
        cmd_next.size_word      = size_word;
        cmd_next.control_word   = control_word;
        cmd_next.draw_mode_word = draw_mode_word;
        cmd_next.raw_x          = {raw_dx, raw_cx, raw_bx, raw_ax};
        cmd_next.raw_y          = {raw_dy, raw_cy, raw_by, raw_ay};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_x_reg <= 16'd0;
            local_y_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scvs_pkg::CFG_LOCAL_X: local_x_reg <= cfg_data;
                scvs_pkg::CFG_LOCAL_Y: local_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= accept;
            res_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
        if (cmd_valid_reg)
            res_reg <= res_next;
    end

    scvs_vertex_calc u_calc
    (
        .cmd     (cmd_reg),
        .local_x (local_x_reg),
        .local_y (local_y_reg),
        .res     (res_next)
    );

    assign done          = res_valid_reg;
    assign status        = res_reg.status;
    assign vert_ax       = $signed(res_reg.vert_x[0]);
    assign vert_ay       = $signed(res_reg.vert_y[0]);
    assign vert_bx       = $signed(res_reg.vert_x[1]);
    assign vert_by       = $signed(res_reg.vert_y[1]);
    assign vert_cx       = $signed(res_reg.vert_x[2]);
    assign vert_cy       = $signed(res_reg.vert_y[2]);
    assign vert_dx       = $signed(res_reg.vert_x[3]);
    assign vert_dy       = $signed(res_reg.vert_y[3]);
    assign sprite_width  = res_reg.sprite_width;
    assign sprite_height = res_reg.sprite_height;
    assign flip_bits     = res_reg.flip_bits;

endmodule

>>> tb/sv/sprite_command_vertex_setup_unit_test.sv
// Self-checking testbench for the sprite command vertex setup unit.
module sprite_command_vertex_setup_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // command kinds with no name in the package
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    // zoom-point anchor: 0 spans A..C, otherwise column = bits 1:0, row = bits 3:2
    localparam logic [3:0] ANCHOR_SPAN  = 4'd0;
    localparam logic [1:0] ALIGN_NONE   = 2'd0;
    localparam logic [1:0] ALIGN_CENTER = 2'd2;
    localparam logic [1:0] ALIGN_FAR    = 2'd3;

    localparam int RandomPhases   = 5;
    localparam int ItemsPerPhase  = 180;
    localparam int MaxPrintedErrs = 60;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] mode;
    logic [15:0] size_word;
    logic [15:0] control_word;
    logic [15:0] draw_mode_word;
    logic [15:0] raw_ax, raw_ay, raw_bx, raw_by, raw_cx, raw_cy, raw_dx, raw_dy;
    logic cfg_valid;
    logic cfg_ready;
    logic [scvs_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic done;
    logic [1:0] status;
    logic signed [15:0] vert_ax, vert_ay, vert_bx, vert_by;
    logic signed [15:0] vert_cx, vert_cy, vert_dx, vert_dy;
    logic [8:0] sprite_width;
    logic [7:0] sprite_height;
    logic [1:0] flip_bits;

    logic [15:0] origin_x;
    logic [15:0] origin_y;
    scvs_pkg::result_t expected_setups[$];
    int mismatch_count;
    int no_gap_left;

    sprite_command_vertex_setup_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .size_word      (size_word),
        .control_word   (control_word),
        .draw_mode_word (draw_mode_word),
        .raw_ax         (raw_ax),
        .raw_ay         (raw_ay),
        .raw_bx         (raw_bx),
        .raw_by         (raw_by),
        .raw_cx         (raw_cx),
        .raw_cy         (raw_cy),
        .raw_dx         (raw_dx),
        .raw_dy         (raw_dy),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .vert_ax        (vert_ax),
        .vert_ay        (vert_ay),
        .vert_bx        (vert_bx),
        .vert_by        (vert_by),
        .vert_cx        (vert_cx),
        .vert_cy        (vert_cy),
        .vert_dx        (vert_dx),
        .vert_dy        (vert_dy),
        .sprite_width   (sprite_width),
        .sprite_height  (sprite_height),
        .flip_bits      (flip_bits)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    // 13-bit coordinate: any of bits 14:12 set means negative
    function automatic logic [15:0] widen_coord(input logic [15:0] raw);
        if (raw[14:12] != 3'b000)
            return {4'hF, raw[11:0]};
        return {5'b00000, raw[10:0]};
    endfunction

    function automatic logic [15:0] halve_toward_zero(input logic [15:0] v);
        int s;
        s = $signed(v);
        return 16'(s / 2);
    endfunction

    function automatic scvs_pkg::result_t setup_vertices(input scvs_pkg::cmd_t c,
                                                         input logic [15:0] lx,
                                                         input logic [15:0] ly);
        scvs_pkg::result_t r;
        logic [15:0] vx[4];
        logic [15:0] vy[4];
        logic [15:0] ax, ay, bx, by, cx, cy, x, y, rw, rh, dw, dh;
        logic [3:0] zp;
        logic [1:0] col, row;
        logic anchored;
        logic [8:0] w;
        logic [7:0] h;
        logic [1:0] flip;
        logic [1:0] st;

        for (int i = 0; i < 4; i++)
        begin
            vx[i] = 16'h0000;
            vy[i] = 16'h0000;
        end
        st = scvs_pkg::STATUS_DRAW;
        w = 9'd1;
        h = 8'd1;
        flip = 2'b00;

        if (c.mode <= scvs_pkg::MODE_DISTORTED)
        begin
            w = {c.size_word[13:8], 3'b000};
            h = c.size_word[7:0];
            flip = c.control_word[5:4];
            if (w == 0 || h == 0)
                st = scvs_pkg::STATUS_EMPTY;
        end

        case (c.mode)
            scvs_pkg::MODE_NORMAL:
            begin
                if (c.size_word[15] || c.draw_mode_word[5:3] > scvs_pkg::MaxColorMode)
                begin
                    st = c.size_word[15] ? scvs_pkg::STATUS_BAD_SIZE
                                         : scvs_pkg::STATUS_BAD_CMOD;
                    w = '0;
                    h = '0;
                    flip = '0;
                end
                else
                begin
                    ax = widen_coord(c.raw_x[0]) + lx;
                    ay = widen_coord(c.raw_y[0]) + ly;
                    dw = (w != 0) ? 16'(w) : 16'd1;
                    dh = (h != 0) ? 16'(h) : 16'd1;
                    vx[0] = ax;      vy[0] = ay;
                    vx[1] = ax + dw; vy[1] = ay;
                    vx[2] = ax + dw; vy[2] = ay + dh;
                    vx[3] = ax;      vy[3] = ay + dh;
                end
            end
            scvs_pkg::MODE_SCALED:
            begin
                ax = widen_coord(c.raw_x[0]);
                ay = widen_coord(c.raw_y[0]);
                bx = widen_coord(c.raw_x[1]);
                by = widen_coord(c.raw_y[1]);
                cx = widen_coord(c.raw_x[2]);
                cy = widen_coord(c.raw_y[2]);
                zp = c.control_word[11:8];
                col = zp[1:0];
                row = zp[3:2];
                // anchors with a zero row or column (other than the span) place no rectangle
                anchored = (col != ALIGN_NONE) && (row != ALIGN_NONE);
                x = ax;
                y = ay;
                rw = '0;
                rh = '0;
                if (zp == ANCHOR_SPAN)
                begin
                    rw = cx - ax;
                    rh = cy - ay;
                end
                else if (anchored)
                begin
                    rw = bx;
                    rh = by;
                    if (col == ALIGN_CENTER)
                        x = x - halve_toward_zero(rw);
                    else if (col == ALIGN_FAR)
                        x = x - rw;
                    if (row == ALIGN_CENTER)
                        y = y - halve_toward_zero(rh);
                    else if (row == ALIGN_FAR)
                        y = y - rh;
                end
                vx[0] = x + lx;      vy[0] = y + ly;
                vx[1] = x + rw + lx; vy[1] = vy[0];
                vx[2] = vx[1];       vy[2] = y + rh + ly;
                vx[3] = vx[0];       vy[3] = vy[2];
                if (zp == ANCHOR_SPAN)
                begin
                    if ($signed(vx[2]) > $signed(vx[0]))
                    begin
                        vx[1] = vx[1] + 1'b1;
                        vx[2] = vx[2] + 1'b1;
                    end
                    else
                        for (int i = 0; i < 4; i++)
                            vx[i] = vx[i] + 1'b1;
                    if ($signed(vy[2]) > $signed(vy[0]))
                    begin
                        vy[2] = vy[2] + 1'b1;
                        vy[3] = vy[3] + 1'b1;
                    end
                    else
                        for (int i = 0; i < 4; i++)
                            vy[i] = vy[i] + 1'b1;
                end
                else if (anchored)
                begin
                    vx[1] = vx[1] + 1'b1;
                    vx[2] = vx[2] + 1'b1;
                    vy[2] = vy[2] + 1'b1;
                    vy[3] = vy[3] + 1'b1;
                end
            end
            scvs_pkg::MODE_DISTORTED, scvs_pkg::MODE_POLYGON, scvs_pkg::MODE_POLYLINE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    vx[i] = widen_coord(c.raw_x[i]) + lx;
                    vy[i] = widen_coord(c.raw_y[i]) + ly;
                end
            end
            scvs_pkg::MODE_LINE:
            begin
                vx[0] = widen_coord(c.raw_x[0]) + lx;
                vy[0] = widen_coord(c.raw_y[0]) + ly;
                vx[1] = widen_coord(c.raw_x[1]) + lx;
                vy[1] = widen_coord(c.raw_y[1]) + ly;
                vx[2] = vx[1]; vy[2] = vy[1];
                vx[3] = vx[0]; vy[3] = vy[0];
            end
            default:
            begin
                w = '0;
                h = '0;
                flip = '0;
            end
        endcase

        r.status = st;
        for (int i = 0; i < 4; i++)
        begin
            r.vert_x[i] = vx[i];
            r.vert_y[i] = vy[i];
        end
        r.sprite_width = w;
        r.sprite_height = h;
        r.flip_bits = flip;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MaxPrintedErrs)
            $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%04h expected 0x%04h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        scvs_pkg::result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_setups.size() == 0)
                flag_mismatch("result with no command outstanding");
            else
            begin
                want = expected_setups.pop_front();
                check_field("status", 16'(status), 16'(want.status));
                check_field("vert_ax", vert_ax, want.vert_x[0]);
                check_field("vert_ay", vert_ay, want.vert_y[0]);
                check_field("vert_bx", vert_bx, want.vert_x[1]);
                check_field("vert_by", vert_by, want.vert_y[1]);
                check_field("vert_cx", vert_cx, want.vert_x[2]);
                check_field("vert_cy", vert_cy, want.vert_y[2]);
                check_field("vert_dx", vert_dx, want.vert_x[3]);
                check_field("vert_dy", vert_dy, want.vert_y[3]);
                check_field("sprite_width", 16'(sprite_width), 16'(want.sprite_width));
                check_field("sprite_height", 16'(sprite_height), 16'(want.sprite_height));
                check_field("flip_bits", 16'(flip_bits), 16'(want.flip_bits));
            end
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic int draw_gap();
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            no_gap_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic send_command(input scvs_pkg::cmd_t c);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode = c.mode;
        size_word = c.size_word;
        control_word = c.control_word;
        draw_mode_word = c.draw_mode_word;
        raw_ax = c.raw_x[0]; raw_ay = c.raw_y[0];
        raw_bx = c.raw_x[1]; raw_by = c.raw_y[1];
        raw_cx = c.raw_x[2]; raw_cy = c.raw_y[2];
        raw_dx = c.raw_x[3]; raw_dy = c.raw_y[3];
        start = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_setups.push_back(setup_vertices(c, origin_x, origin_y));
    endtask

    // every command yields a result, so an empty queue plus pipeline depth means idle
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_setups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [scvs_pkg::CfgIndexWidth-1:0] idx,
                                  input logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == scvs_pkg::CFG_LOCAL_X)
            origin_x = value;
        else
            origin_y = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_origin(input logic [15:0] lx, input logic [15:0] ly);
        drain_results();
        write_register(scvs_pkg::CFG_LOCAL_X, lx);
        write_register(scvs_pkg::CFG_LOCAL_Y, ly);
    endtask

    function automatic scvs_pkg::cmd_t make_command(input logic [2:0] m,
                                          input logic [15:0] sz,
                                          input logic [15:0] ctl, input logic [15:0] pm,
                                          input logic [15:0] ax, input logic [15:0] ay,
                                          input logic [15:0] bx, input logic [15:0] by,
                                          input logic [15:0] cx, input logic [15:0] cy,
                                          input logic [15:0] dx, input logic [15:0] dy);
        scvs_pkg::cmd_t c;
        c.mode = m;
        c.size_word = sz;
        c.control_word = ctl;
        c.draw_mode_word = pm;
        c.raw_x = {dx, cx, bx, ax};
        c.raw_y = {dy, cy, by, ay};
        return c;
    endfunction

    function automatic logic [15:0] random_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 16'($urandom);
        if (pick < 7)
            return 16'($urandom_range(0, 16'h07FF));
        if (pick < 9)
            return {4'hF, 12'($urandom)};
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            default: return 16'h8000;
        endcase
    endfunction

    function automatic scvs_pkg::cmd_t random_command();
        scvs_pkg::cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            c.mode = scvs_pkg::MODE_NORMAL;
        else if (pick < 50)
            c.mode = scvs_pkg::MODE_SCALED;
        else if (pick < 60)
            c.mode = scvs_pkg::MODE_DISTORTED;
        else if (pick < 70)
            c.mode = scvs_pkg::MODE_POLYGON;
        else if (pick < 80)
            c.mode = scvs_pkg::MODE_POLYLINE;
        else if (pick < 94)
            c.mode = scvs_pkg::MODE_LINE;
        else
            c.mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
        c.size_word = 16'($urandom);
        c.control_word = 16'($urandom);
        c.draw_mode_word = 16'($urandom);
        // keep most normal sprites drawable; the rest exercise the error paths
        if ($urandom_range(0, 6) != 0)
            c.size_word[15] = 1'b0;
        if ($urandom_range(0, 4) != 0 && c.draw_mode_word[5:3] > scvs_pkg::MaxColorMode)
            c.draw_mode_word[5:3] = 3'($urandom_range(0, 5));
        if ($urandom_range(0, 19) == 0)
            c.size_word[13:8] = '0;
        if ($urandom_range(0, 19) == 0)
            c.size_word[7:0] = '0;
        for (int i = 0; i < 4; i++)
        begin
            c.raw_x[i] = random_coord();
            c.raw_y[i] = random_coord();
        end
        return c;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_each_mode();
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h0510, 16'h0010, 16'h0000,
                                  16'h0020, 16'h0030, 0, 0, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0208, 16'h0520, 16'h0008,
                                  16'h0040, 16'h0040, 16'h0011, 16'h0013, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_DISTORTED, 16'h3FFF, 16'h0030, 16'h0028,
                                  16'h0001, 16'h0002, 16'h0003, 16'h0004,
                                  16'h0005, 16'h0006, 16'h0007, 16'h0008));
        send_command(make_command(scvs_pkg::MODE_POLYGON, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'h0100, 16'hF100, 16'h0200, 16'hF200,
                                  16'h0300, 16'hF300, 16'h0400, 16'hF400));
        send_command(make_command(scvs_pkg::MODE_POLYLINE, 16'h8000, 16'h0000, 16'h0038,
                                  16'h07FF, 16'h0800, 16'h1000, 16'h7FFF,
                                  16'h8000, 16'hFFFF, 16'h0000, 16'h0FFF));
        send_command(make_command(scvs_pkg::MODE_LINE, 16'h0000, 16'h0F30, 16'h0030,
                                  16'h0123, 16'h0456, 16'hF789, 16'hFABC,
                                  16'h0111, 16'h0222, 16'h0333, 16'h0444));
        send_command(make_command(MODE_SPARE_6, 16'h0510, 16'h0030, 16'h0000,
                                  16'h0020, 16'h0030, 16'h0040, 16'h0050,
                                  16'h0060, 16'h0070, 16'h0080, 16'h0090));
        send_command(make_command(MODE_SPARE_7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_normal_status();
        // size bit 15 alone, bad colour mode alone, both (size wins), then empty sizes
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h8510, 16'h0030, 16'h0000,
                                  16'h0020, 16'h0030, 0, 0, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h0510, 16'h0030, 16'h0030,
                                  16'h0020, 16'h0030, 0, 0, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h8510, 16'h0030, 16'h0038,
                                  16'h0020, 16'h0030, 0, 0, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h00FF, 16'h0010, 16'h0028,
                                  16'h07FF, 16'h0001, 0, 0, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h3F00, 16'h0020, 16'h0000,
                                  16'hF800, 16'h7FFF, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_scaled_anchors();
        // span anchor with C right of/below A, then with C at/left of/above A
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0101, 16'h0000, 16'h0000,
                                  16'h0010, 16'h0020, 0, 0, 16'h0050, 16'h0060, 0, 0));
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0101, 16'h0000, 16'h0038,
                                  16'h0050, 16'h0060, 0, 0, 16'h0010, 16'h0060, 0, 0));
        // centre anchors with odd sizes, some negative: halving truncates toward zero; then a far anchor
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0101, 16'h0600, 16'h0000,
                                  16'h0100, 16'h0100, 16'hF003, 16'h0007, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0101, 16'h0A00, 16'h0000,
                                  16'h0100, 16'h0100, 16'h0005, 16'hFFFD, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0101, 16'h0F00, 16'h0000,
                                  16'h7FFF, 16'h8000, 16'h07FF, 16'hF000, 0, 0, 0, 0));
        // anchor with a zero column: no rectangle, no adjustment
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'h0101, 16'h0400, 16'h0000,
                                  16'h0100, 16'h0200, 16'h0030, 16'h0040, 0, 0, 0, 0));
    endtask

    task automatic test_origin_extremes();
        set_origin(16'h7FFF, 16'h8000);
        send_command(make_command(scvs_pkg::MODE_NORMAL, 16'h3FFF, 16'h0030, 16'h0000,
                                  16'h07FF, 16'h0800, 0, 0, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_POLYGON, 16'h0000, 16'h0000, 16'h0000,
                                  16'hFFFF, 16'h0000, 16'h07FF, 16'hF000,
                                  16'h1000, 16'h0800, 16'h7000, 16'h8FFF));
        set_origin(16'h8000, 16'h7FFF);
        send_command(make_command(scvs_pkg::MODE_SCALED, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'h07FF, 16'h07FF, 16'hF000, 0, 0, 0, 0));
        send_command(make_command(scvs_pkg::MODE_LINE, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 0, 0, 0, 0));
    endtask

    task automatic test_random_commands();
        logic [15:0] origins_x[RandomPhases];
        logic [15:0] origins_y[RandomPhases];
        origins_x = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'($urandom)};
        origins_y = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'($urandom)};
        for (int p = 0; p < RandomPhases; p++)
        begin
            set_origin(origins_x[p], origins_y[p]);
            for (int n = 0; n < ItemsPerPhase; n++)
                send_command(random_command());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = '0;
        size_word = '0;
        control_word = '0;
        draw_mode_word = '0;
        raw_ax = '0; raw_ay = '0; raw_bx = '0; raw_by = '0;
        raw_cx = '0; raw_cy = '0; raw_dx = '0; raw_dy = '0;
        cfg_valid = 1'b0;
        cfg_index = scvs_pkg::CFG_LOCAL_X;
        cfg_data = '0;
        origin_x = '0;
        origin_y = '0;
        mismatch_count = 0;
        no_gap_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_each_mode();
        test_normal_status();
        test_scaled_anchors();
        test_origin_extremes();
        test_random_commands();
        drain_results();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // roughly 950 commands take well under a millisecond
    initial
    begin
        #(5ms);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sprite_command_vertex_setup_unit.f
hdl/scvs_pkg.sv
hdl/scvs_vertex_calc.sv
hdl/sprite_command_vertex_setup_unit.sv
tb/sv/sprite_command_vertex_setup_unit_test.sv
